// File: hw/rtl/aesbc_pkg.sv
// ----------------------------------------------------------------------------
// AES block cipher package
// Shared types, S-box tables and round functions for the AES engine.
// ----------------------------------------------------------------------------
package aesbc_pkg;

  localparam int RkWords   = 60;
  localparam int MaxRounds = 14;
  localparam int RkIdxW    = $clog2(RkWords);

  // Configuration register indexes.
  localparam logic [2:0] CFG_MODE = 3'd0;
  localparam logic [2:0] CFG_KEY0 = 3'd1;
  localparam logic [2:0] CFG_KEY3 = 3'd4;

  // Operation codes.
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef struct packed {
    logic        op;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
  } aesbc_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } aesbc_out_t;

  // Byte k of the state is row k/4, column k%4; byte 0 is most significant.
  typedef logic [0:15][7:0] state_t;
  typedef logic [7:0] sbox_arr_t [256];

  localparam sbox_arr_t SBOX = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // The inverse table is built from the forward one at elaboration.
  function automatic sbox_arr_t inv_table();
    sbox_arr_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam sbox_arr_t INV_SBOX = inv_table();

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Multiply by a constant coefficient below 16.
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    return p;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic state_t sub_bytes(input state_t s, input logic inv);
    state_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = inv ? INV_SBOX[s[i]] : SBOX[s[i]];
    end
    return t;
  endfunction

  function automatic state_t shift_rows(input state_t s, input logic inv);
    state_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[r*4+c] = inv ? s[r*4+((c-r+4)%4)] : s[r*4+((c+r)%4)];
      end
    end
    return t;
  endfunction

  function automatic state_t mix_columns(input state_t s, input logic inv);
    state_t     t;
    logic [3:0] m [4];
    logic [7:0] acc;
    if (inv) m = '{4'd14, 4'd11, 4'd13, 4'd9};
    else     m = '{4'd2, 4'd3, 4'd1, 4'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gmul(s[k*4+c], m[(k-r+4)%4]);
        end
        t[r*4+c] = acc;
      end
    end
    return t;
  endfunction

  // Round key as a state: column c comes from word c, row 0 in the top byte.
  function automatic state_t rk_state(input logic [31:0] w0, input logic [31:0] w1,
                                      input logic [31:0] w2, input logic [31:0] w3);
    logic [31:0] w [4];
    state_t      t;
    w = '{w0, w1, w2, w3};
    for (int i = 0; i < 16; i++) begin
      t[i] = w[i%4][31-8*(i/4) -: 8];
    end
    return t;
  endfunction

endpackage

// File: hw/rtl/aes_block_cipher_enc_dec_top.sv
// ----------------------------------------------------------------------------
// AES block cipher, encrypt and decrypt
// There are fifteen register stages (one initial key stage plus fourteen round
// stages), and the first one loads at the accepting edge. Throughput is one item
// per cycle while the output is not stalled and the round keys are ready.
// Shorter keys pass unused round stages unchanged, so every key size uses the
// same path. After reset or a mode or key register write, a start step and then
// key expansion of 44, 52 or 60 words (one word per cycle) run before the first
// item is accepted.
// Reset is synchronous: it clears the pipeline valids, mode, keys and status.
// ----------------------------------------------------------------------------
module aes_block_cipher_enc_dec_top
  import aesbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  aesbc_in_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output aesbc_out_t  out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // Configuration registers.
  logic [1:0]  mode_r;
  logic [63:0] key_r [4];
  logic        cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index <= CFG_KEY3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) begin
        mode_r <= cfg_wdata[1:0];
      end else if (cfg_index <= CFG_KEY3) begin
        key_r[2'(cfg_index - CFG_KEY0)] <= cfg_wdata;
      end
    end
  end

  // Round and key-length decode; the unused mode code acts as a 256-bit key.
  logic [3:0] nr;
  logic [3:0] nk;
  logic [5:0] total;

  always_comb begin
    unique case (mode_r)
      2'd0:    begin nr = 4'd10; nk = 4'd4; total = 6'd44; end
      2'd1:    begin nr = 4'd12; nk = 4'd6; total = 6'd52; end
      default: begin nr = 4'd14; nk = 4'd8; total = 6'd60; end
    endcase
  end

  // Key expansion sequencer: one word per cycle into the key store.
  logic              keys_rdy_r;
  logic              ex_busy_r;
  logic [RkIdxW-1:0] ex_i_r;
  logic [2:0]        ex_m_r;
  logic [7:0]        rcon_r;
  logic [31:0]       win_r [8];
  logic [31:0]       rk_r [RkWords];
  logic [31:0]       ex_word;
  logic [31:0]       ex_t;
  logic              ex_rcon_step;
  logic [63:0]       ex_kreg;

  always_comb begin
    ex_kreg      = key_r[ex_i_r[2:1]];
    ex_t         = win_r[0];
    ex_rcon_step = 1'b0;
    if (ex_i_r < RkIdxW'(nk)) begin
      ex_word = ex_i_r[0] ? ex_kreg[31:0] : ex_kreg[63:32];
    end else begin
      if (ex_m_r == 3'd0) begin
        ex_t         = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rcon_r, 24'h0};
        ex_rcon_step = 1'b1;
      end else if (nk > 4'd6 && ex_m_r == 3'd4) begin
        ex_t = sub_word(win_r[0]);
      end
      ex_word = win_r[3'(nk - 4'd1)] ^ ex_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_rdy_r <= 1'b0;
      ex_busy_r  <= 1'b0;
      ex_i_r     <= '0;
      ex_m_r     <= '0;
      rcon_r     <= 8'h01;
    end else if (cfg_hit) begin
      keys_rdy_r <= 1'b0;
      ex_busy_r  <= 1'b0;
    end else if (!keys_rdy_r && !ex_busy_r) begin
      ex_busy_r <= 1'b1;
      ex_i_r    <= '0;
      ex_m_r    <= '0;
      rcon_r    <= 8'h01;
    end else if (ex_busy_r) begin
      ex_i_r <= ex_i_r + 1'b1;
      ex_m_r <= (ex_m_r == 3'(nk - 4'd1)) ? 3'd0 : ex_m_r + 1'b1;
      if (ex_rcon_step) rcon_r <= xtime(rcon_r);
      if (ex_i_r == total - 6'd1) begin
        ex_busy_r  <= 1'b0;
        keys_rdy_r <= 1'b1;
      end
    end
  end

  // Key store and history window; payload only, no reset.
  always_ff @(posedge clk) begin
    if (ex_busy_r && !cfg_hit) begin
      rk_r[ex_i_r] <= ex_word;
      win_r[0]     <= ex_word;
      for (int k = 1; k < 8; k++) win_r[k] <= win_r[k-1];
    end
  end

  // Round keys as states, each read from fixed store words.
  state_t rks [MaxRounds+1];

  always_comb begin
    for (int r = 0; r <= MaxRounds; r++) begin
      rks[r] = rk_state(rk_r[4*r], rk_r[4*r+1], rk_r[4*r+2], rk_r[4*r+3]);
    end
  end

  // Pipeline: stage 0 adds the first key, stages 1 to nr run one round each, later ones pass.
  logic   en;
  state_t st_r  [MaxRounds+1];
  logic   v_r   [MaxRounds+1];
  logic   op_r  [MaxRounds+1];
  state_t st_nxt[MaxRounds+1];
  state_t key0;
  state_t kj;
  state_t t;

  assign en       = !v_r[MaxRounds] || out_ready;
  assign in_ready = en && keys_rdy_r;

  always_comb begin
    unique case (nr)
      4'd10:   key0 = rks[10];
      4'd12:   key0 = rks[12];
      default: key0 = rks[14];
    endcase
    if (in_data.op == OP_ENC) key0 = rks[0];
    st_nxt[0] = state_t'({in_data.data_hi, in_data.data_lo}) ^ key0;
    for (int j = 1; j <= MaxRounds; j++) begin
      // Decrypt stage j uses round key nr - j.
      kj = rks[0];
      if (op_r[j-1] == OP_ENC) begin
        kj = rks[j];
      end else if (nr == 4'd10) begin
        if (j <= 10) kj = rks[(j <= 10) ? 10 - j : 0];
      end else if (nr == 4'd12) begin
        if (j <= 12) kj = rks[(j <= 12) ? 12 - j : 0];
      end else begin
        kj = rks[14 - j];
      end
      t = st_r[j-1];
      if (4'(j) <= nr) begin
        if (op_r[j-1] == OP_ENC) begin
          t = shift_rows(sub_bytes(t, 1'b0), 1'b0);
          if (4'(j) != nr) t = mix_columns(t, 1'b0);
          t = t ^ kj;
        end else begin
          t = sub_bytes(shift_rows(t, 1'b1), 1'b1) ^ kj;
          if (4'(j) != nr) t = mix_columns(t, 1'b1);
        end
      end
      st_nxt[j] = t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= MaxRounds; j++) v_r[j] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid && in_ready;
      for (int j = 1; j <= MaxRounds; j++) v_r[j] <= v_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st_nxt[0];
      op_r[0] <= in_data.op;
      for (int j = 1; j <= MaxRounds; j++) begin
        st_r[j] <= st_nxt[j];
        op_r[j] <= op_r[j-1];
      end
    end
  end

  assign out_valid          = v_r[MaxRounds];
  assign out_data.result_hi = st_r[MaxRounds][0:7];
  assign out_data.result_lo = st_r[MaxRounds][8:15];

  // A stalled result freezes every stage; checked on the valids of stages 0 and 7.
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[MaxRounds] && !out_ready) |=> $stable(v_r[0]) && $stable(v_r[7]))
    else $error("pipeline moved during output stall");

  // No item enters while the key store is being built.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ex_busy_r |-> !in_ready)
    else $error("item accepted during key expansion");

  // Keys become ready only at the end of an expansion run.
  a_ready_after_exp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(keys_rdy_r) |-> $past(ex_busy_r))
    else $error("keys ready without expansion");

  // An accepted item shows up in the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted item lost at entry");

endmodule

// File: tb/aes_block_cipher_enc_dec_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES block cipher result checker
// Watches the configuration port and both item channels, keeps its own copy
// of the mode, cipher key and expanded round keys, predicts each processed
// block and compares every result item field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module aes_block_cipher_enc_dec_checker
  import aesbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  aesbc_in_t   in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  aesbc_out_t  out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          pending,
  output int          errors
);

  logic [7:0]  fwd_sb [256];
  logic [7:0]  inv_sb [256];
  logic [1:0]  key_mode;
  logic [63:0] key_words [4];
  logic [31:0] sched [60];
  logic        sched_valid;
  aesbc_out_t  block_q [$];

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = gf_dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rot8(input logic [7:0] x, input int n);
    return 8'((x << n) | (x >> (8 - n)));
  endfunction

  // The forward table is the affine map of the field inverse (a^254).
  initial begin
    logic [7:0] r, base, b;
    for (int v = 0; v < 256; v++) begin
      r = 8'h01;
      base = 8'(v);
      for (int e = 254; e != 0; e = e >> 1) begin
        if (e & 1) r = gf_prod(r, base);
        base = gf_prod(base, base);
      end
      b = r ^ rot8(r, 1) ^ rot8(r, 2) ^ rot8(r, 3) ^ rot8(r, 4) ^ 8'h63;
      fwd_sb[v] = b;
      inv_sb[b] = 8'(v);
    end
  end

  function automatic logic [31:0] sub_w(input logic [31:0] w);
    return {fwd_sb[w[31:24]], fwd_sb[w[23:16]], fwd_sb[w[15:8]], fwd_sb[w[7:0]]};
  endfunction

  function automatic int round_count();
    int m;
    m = (key_mode > 2) ? 2 : key_mode;
    return 10 + 2 * m;
  endfunction

  // Standard key expansion, with the extra SubWord step for 256-bit keys.
  task automatic build_schedule();
    int          nk, total;
    logic [7:0]  rc;
    logic [31:0] t;
    nk = round_count() - 6;
    total = 4 * (round_count() + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++) begin
      sched[i] = i[0] ? key_words[i >> 1][31:0] : key_words[i >> 1][63:32];
    end
    for (int i = nk; i < total; i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_w(t);
      end
      sched[i] = sched[i-nk] ^ t;
    end
    sched_valid = 1'b1;
  endtask

  function automatic aesbc_out_t cipher_block(input aesbc_in_t item);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] coef [4];
    logic [7:0] acc;
    logic       dec;
    int         nr, rnd;
    aesbc_out_t res;
    nr = round_count();
    dec = (item.op == OP_DEC);
    if (dec) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else     coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int i = 0; i < 8; i++) begin
      s[i]   = item.data_hi[63-8*i -: 8];
      s[i+8] = item.data_lo[63-8*i -: 8];
    end
    // Step 0 is the first key add; each later step is one round.
    for (int step = 0; step <= nr; step++) begin
      rnd = dec ? nr - step : step;
      if (step > 0) begin
        // ShiftRows and SubBytes commute, so one form serves both directions.
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            t[r*4+c] = dec ? inv_sb[s[r*4+((c-r+4)%4)]] : fwd_sb[s[r*4+((c+r)%4)]];
          end
        end
        s = t;
        if (!dec && step < nr) begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
              acc = 8'h00;
              for (int k = 0; k < 4; k++) acc ^= gf_prod(coef[(k-r+4)%4], s[k*4+c]);
              t[r*4+c] = acc;
            end
          end
          s = t;
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= sched[4*rnd + i%4][31-8*(i/4) -: 8];
      // The inverse cipher mixes after the key add of its middle rounds.
      if (dec && step > 0 && step < nr) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) acc ^= gf_prod(coef[(k-r+4)%4], s[k*4+c]);
            t[r*4+c] = acc;
          end
        end
        s = t;
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.result_hi[63-8*i -: 8] = s[i];
      res.result_lo[63-8*i -: 8] = s[i+8];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t checker: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = block_q.size();

  always @(posedge clk) begin
    aesbc_out_t want;
    if (!rst_n) begin
      key_mode = 2'd0;
      key_words = '{default: 64'h0};
      sched_valid = 1'b0;
      block_q.delete();
    end else begin
      // Register writes; indexes past the last key register are ignored.
      if (cfg_we) begin
        if (cfg_index == CFG_MODE) begin
          key_mode = cfg_wdata[1:0];
          sched_valid = 1'b0;
        end else if (cfg_index <= CFG_KEY3) begin
          key_words[cfg_index - CFG_KEY0] = cfg_wdata;
          sched_valid = 1'b0;
        end
      end
      if (in_valid && in_ready) begin
        if (!sched_valid) build_schedule();
        block_q.push_back(cipher_block(in_data));
      end
      if (out_valid && out_ready) begin
        if (block_q.size() == 0) begin
          $display("%0t checker: result item with none expected", $time);
          errors++;
        end else begin
          want = block_q.pop_front();
          if (out_data.result_hi !== want.result_hi)
            report_mismatch("result_hi", out_data.result_hi, want.result_hi);
          if (out_data.result_lo !== want.result_lo)
            report_mismatch("result_lo", out_data.result_lo, want.result_lo);
        end
      end
    end
  end

endmodule

// File: tb/aes_block_cipher_enc_dec_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES block cipher testbench
// Drives known vectors and then random blocks through several key sizes and
// keys, with random idling on both channels, and leaves the checking to the
// checker module beside the block.
// ----------------------------------------------------------------------------
module aes_block_cipher_enc_dec_top_test;
  import aesbc_pkg::*;

  localparam logic [2:0] CFG_UNUSED_LO = CFG_KEY3 + 3'd1;
  localparam int         NUM_PHASES    = 10;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  aesbc_in_t   in_data;
  logic        out_valid;
  logic        out_ready;
  aesbc_out_t  out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  int          pending;
  int          errors;
  bit          hold_req;
  bit          busy_phase;

  aes_block_cipher_enc_dec_top u_top (.*);

  aes_block_cipher_enc_dec_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly back to back or short gaps, sometimes a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (busy_phase || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pattern64();
    case ($urandom_range(0, 9))
      0:       return 64'h0;
      1:       return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
    int g;
    in_valid <= 1'b1;
    in_data  <= '{op: op, data_hi: hi, data_lo: lo};
    do @(posedge clk); while (!in_ready);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // The write enable is left high; the caller lowers it after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ready <= busy_phase ? 1'b1 : ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 99) < 2) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end else begin
          @(posedge clk);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    logic [1:0] mode;
    logic [63:0] kfill;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_req  = 1'b0;
    busy_phase = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Known vector key and block, then field extremes in both directions.
    write_reg(CFG_MODE, 64'd0);
    write_reg(CFG_KEY0, 64'h0001020304050607);
    write_reg(CFG_KEY0 + 3'd1, 64'h08090a0b0c0d0e0f);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OP_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(OP_ENC, 64'h0, 64'h0);
    send_block(OP_DEC, 64'h0, 64'h0);
    send_block(OP_ENC, '1, '1);
    send_block(OP_DEC, '1, '1);
    send_block(OP_ENC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_block(OP_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();

    // Each mode with all-zero and all-one keys; mode 3 acts as 256-bit.
    for (int m = 0; m < 4; m++) begin
      for (int z = 0; z < 2; z++) begin
        kfill = z ? '1 : '0;
        write_reg(CFG_MODE, {62'h0, 2'(m)});
        for (int k = 0; k < 4; k++) write_reg(CFG_KEY0 + 3'(k), kfill);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_block(OP_ENC, 64'h0123456789abcdef, '1);
        send_block(OP_DEC, '0, 64'hfedcba9876543210);
        drain();
      end
    end

    // Random phases, each with new settings.
    for (int p = 0; p < NUM_PHASES; p++) begin
      mode = 2'(p % 4);
      write_reg(CFG_MODE, {rand64() & ~64'h3} | {62'h0, mode});
      for (int k = 0; k < 4; k++) write_reg(CFG_KEY0 + 3'(k), pattern64());
      // Writes to unused indexes must change nothing.
      write_reg(CFG_UNUSED_LO + 3'($urandom_range(0, 2)), rand64());
      cfg_we <= 1'b0;
      @(posedge clk);
      busy_phase = (p == 2);
      for (int n = 0; n < 130; n++) begin
        if (p == 2 && n == 20) hold_req = 1'b1;
        if (p == 3 && n == 65) drain();
        send_block(1'($urandom), pattern64(), pattern64());
      end
      busy_phase = 1'b0;
      drain();
    end

    repeat (30) @(posedge clk);
    if (errors == 0) $display("aes_block_cipher_enc_dec_top_test: done, clean");
    else $display("aes_block_cipher_enc_dec_top_test: done, errors");
    $finish;
  end

  initial begin
    #1500000;
    $display("aes_block_cipher_enc_dec_top_test: done, errors");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/aesbc_pkg.sv
hw/rtl/aes_block_cipher_enc_dec_top.sv
tb/aes_block_cipher_enc_dec_checker.sv
tb/aes_block_cipher_enc_dec_top_test.sv
